@@ sv/daisy_chain_pec_framer_checker_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the daisy-chain PEC framer/checker
// Clocked on clk and disabled during reset on rst_n.
// ---------------------------------------------------------------------------
`ifndef DAISY_CHAIN_PEC_FRAMER_CHECKER_TOP_MACROS_SVH
`define DAISY_CHAIN_PEC_FRAMER_CHECKER_TOP_MACROS_SVH

`ifndef SYNTH
// plain property check
`define DCPF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define DCPF_ASSERT_IMP(lbl, ante, cons, msg) \
    `DCPF_ASSERT(lbl, (ante) |-> (cons), msg)
`else
`define DCPF_ASSERT(lbl, prop, msg)
`define DCPF_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

@@ sv/dcpf_pkg.sv @@
// ---------------------------------------------------------------------------
// dcpf_pkg
// Types, codes and the CRC-15 PEC step shared by the framer/checker.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dcpf_pkg;

    // input actions
    localparam logic [1:0] ACT_CMD   = 2'd0;
    localparam logic [1:0] ACT_RX    = 2'd1;
    localparam logic [1:0] ACT_FAULT = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // result kinds, also used as job types in the queue
    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_CHECK = 2'd2;
    localparam logic [1:0] KIND_ABORT = 2'd3;

    // transaction status
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_LINK    = 2'd2;

    localparam logic [14:0] PEC_SEED   = 15'd16;
    localparam logic [14:0] PEC_POLY   = 15'h4599;
    localparam logic [2:0]  DATA_BYTES = 3'd6;
    localparam int          MAX_CHAIN  = 32;
    localparam int          CHAIN_W    = 6;

    localparam int unsigned JOB_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] command;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [4:0] device_index;
        logic       pec_ok;
        logic [1:0] status;
        logic       end_of_frame;
    } out_item_t;

    // classified work handed from front to back
    typedef struct packed {
        logic [1:0]  jtype;
        logic [15:0] payload;
        logic [4:0]  dev;
        logic        ok;
        logic [1:0]  status;
        logic        eof;
    } job_t;

    // one byte of CRC-15, MSB first
    function automatic logic [14:0] pec_update(input logic [14:0] rem,
                                               input logic [7:0] data);
        logic [14:0] r;
        logic        fb;
        r = rem;
        for (int b = 7; b >= 0; b--)
        begin
            fb = r[14] ^ data[b];
            r  = {r[13:0], 1'b0};
            if (fb)
            begin
                r = r ^ PEC_POLY;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/dcpf_front.sv @@
// ---------------------------------------------------------------------------
// dcpf_front
// Accepts items, tracks reply framing and PEC, classifies into queue jobs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "daisy_chain_pec_framer_checker_top_macros.svh"

module dcpf_front (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire dcpf_pkg::in_item_t  item,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [5:0]          cfg_data,
    output logic                     job_push,
    output dcpf_pkg::job_t           job,
    input  wire logic                queue_full
);
    import dcpf_pkg::*;

    logic [CHAIN_W-1:0] chain_length_reg;
    logic [14:0]        rem_reg,       rem_next;
    logic [2:0]         pos_reg,       pos_next;
    logic [4:0]         dev_reg,       dev_next;
    logic [7:0]         pec_high_reg,  pec_high_next;
    logic               mismatch_reg,  mismatch_next;
    logic               active_reg,    active_next;

    logic        accept;
    logic [4:0]  last_idx;
    logic        pec_match;
    logic        last_dev;

    assign item_stall = queue_full;
    assign cfg_ready  = 1'b1;
    assign accept     = item_valid && !queue_full;

    // clamp the chain length to 1..32 and take the last device index
    always_comb
    begin
        if (chain_length_reg == '0)
        begin
            last_idx = '0;
        end
        else if (chain_length_reg > CHAIN_W'(MAX_CHAIN))
        begin
            last_idx = 5'(MAX_CHAIN - 1);
        end
        else
        begin
            last_idx = 5'(chain_length_reg - CHAIN_W'(1));
        end
    end

    assign pec_match = ({rem_reg, 1'b0} == {pec_high_reg, item.rx_byte});
    assign last_dev  = (dev_reg >= last_idx);

    always_comb
    begin
        rem_next      = rem_reg;
        pos_next      = pos_reg;
        dev_next      = dev_reg;
        pec_high_next = pec_high_reg;
        mismatch_next = mismatch_reg;
        active_next   = active_reg;
        job_push      = 1'b0;
        job           = '0;
        if (accept)
        begin
            unique case (item.action)
                ACT_CMD:
                begin
                    job_push      = 1'b1;
                    job.jtype     = KIND_TX;
                    job.payload   = item.command;
                    active_next   = 1'b1;
                    pos_next      = '0;
                    dev_next      = '0;
                    mismatch_next = 1'b0;
                    pec_high_next = '0;
                    rem_next      = PEC_SEED;
                end
                ACT_FAULT:
                begin
                    job_push    = 1'b1;
                    job.jtype   = KIND_ABORT;
                    job.dev     = dev_reg;
                    job.status  = ST_LINK;
                    job.eof     = 1'b1;
                    active_next = 1'b0;
                    pos_next    = '0;
                    dev_next    = '0;
                    rem_next    = PEC_SEED;
                end
                ACT_RX:
                begin
                    if (active_reg)
                    begin
                        if (pos_reg < DATA_BYTES)
                        begin
                            // data byte: pass through and fold into the PEC
                            job_push    = 1'b1;
                            job.jtype   = KIND_DATA;
                            job.payload = {8'd0, item.rx_byte};
                            job.dev     = dev_reg;
                            rem_next    = pec_update(rem_reg, item.rx_byte);
                            pos_next    = pos_reg + 3'd1;
                        end
                        else if (pos_reg == DATA_BYTES)
                        begin
                            pec_high_next = item.rx_byte;
                            pos_next      = pos_reg + 3'd1;
                        end
                        else
                        begin
                            // second PEC byte: check this device
                            mismatch_next = mismatch_reg | !pec_match;
                            job_push      = 1'b1;
                            job.jtype     = KIND_CHECK;
                            job.dev       = dev_reg;
                            job.ok        = pec_match;
                            job.status    = mismatch_next ? ST_INVALID : ST_OK;
                            job.eof       = last_dev;
                            pos_next      = '0;
                            rem_next      = PEC_SEED;
                            if (last_dev)
                            begin
                                active_next = 1'b0;
                                dev_next    = '0;
                            end
                            else
                            begin
                                dev_next = dev_reg + 5'd1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_length_reg <= CHAIN_W'(1);
            rem_reg          <= PEC_SEED;
            pos_reg          <= '0;
            dev_reg          <= '0;
            pec_high_reg     <= '0;
            mismatch_reg     <= 1'b0;
            active_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                chain_length_reg <= cfg_data;
            end
            rem_reg      <= rem_next;
            pos_reg      <= pos_next;
            dev_reg      <= dev_next;
            pec_high_reg <= pec_high_next;
            mismatch_reg <= mismatch_next;
            active_reg   <= active_next;
        end
    end

    `DCPF_ASSERT_IMP(a_pos_needs_reply, pos_reg != '0, active_reg, "byte position set with no open reply")
    `DCPF_ASSERT_IMP(a_dev_needs_reply, dev_reg != '0, active_reg, "device counter set with no open reply")
    `DCPF_ASSERT_IMP(a_no_push_full, job_push, !queue_full, "job pushed into a full queue")

endmodule

`default_nettype wire

@@ sv/dcpf_queue.sv @@
// ---------------------------------------------------------------------------
// dcpf_queue
// Small job FIFO that decouples the classifier from the beat serializer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dcpf_queue #(
    parameter int unsigned DEPTH = dcpf_pkg::JOB_QUEUE_DEPTH
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire dcpf_pkg::job_t  din,
    output logic                 full,
    input  wire logic            pop,
    output dcpf_pkg::job_t       dout,
    output logic                 empty
);
    import dcpf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr;
    logic             do_rd;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = push && !full;
    assign do_rd = pop && !empty;
    assign dout  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/dcpf_back.sv @@
// ---------------------------------------------------------------------------
// dcpf_back
// Turns queued jobs into result beats; serializes command frames.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "daisy_chain_pec_framer_checker_top_macros.svh"

module dcpf_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               job_valid,
    input  wire dcpf_pkg::job_t     job,
    output logic                    job_pop,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output dcpf_pkg::out_item_t     result
);
    import dcpf_pkg::*;

    localparam logic [1:0] STEP_IDLE = 2'd0;
    localparam logic [1:0] STEP_LO   = 2'd1;
    localparam logic [1:0] STEP_PHI  = 2'd2;
    localparam logic [1:0] STEP_PLO  = 2'd3;

    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg,       out_next;
    logic [1:0]  step_reg,      step_next;
    logic [7:0]  lo_reg,        lo_next;
    logic [14:0] crc_reg,       crc_next;

    logic      load;
    logic      beat_valid;
    out_item_t beat;

    assign load         = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        step_next  = step_reg;
        lo_next    = lo_reg;
        crc_next   = crc_reg;
        job_pop    = 1'b0;
        beat_valid = 1'b0;
        beat       = '0;
        if (load)
        begin
            if (step_reg != STEP_IDLE)
            begin
                // continue the transmit frame
                beat_valid = 1'b1;
                beat.kind  = KIND_TX;
                unique case (step_reg)
                    STEP_LO:
                    begin
                        beat.out_byte = lo_reg;
                        crc_next      = pec_update(crc_reg, lo_reg);
                        step_next     = STEP_PHI;
                    end
                    STEP_PHI:
                    begin
                        beat.out_byte = crc_reg[14:7];
                        step_next     = STEP_PLO;
                    end
                    STEP_PLO:
                    begin
                        beat.out_byte     = {crc_reg[6:0], 1'b0};
                        beat.end_of_frame = 1'b1;
                        step_next         = STEP_IDLE;
                    end
                    default:
                    begin
                        step_next = STEP_IDLE;
                    end
                endcase
            end
            else if (job_valid)
            begin
                job_pop    = 1'b1;
                beat_valid = 1'b1;
                case (job.jtype)
                    KIND_TX:
                    begin
                        beat.kind     = KIND_TX;
                        beat.out_byte = job.payload[15:8];
                        lo_next       = job.payload[7:0];
                        crc_next      = pec_update(PEC_SEED, job.payload[15:8]);
                        step_next     = STEP_LO;
                    end
                    default:
                    begin
                        beat.kind         = job.jtype;
                        beat.out_byte     = job.payload[7:0];
                        beat.device_index = job.dev;
                        beat.pec_ok       = job.ok;
                        beat.status       = job.status;
                        beat.end_of_frame = job.eof;
                    end
                endcase
            end
        end
        out_valid_next = load ? beat_valid : out_valid_reg;
        out_next       = (load && beat_valid) ? beat : out_reg;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        lo_reg  <= lo_next;
        crc_reg <= crc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= STEP_IDLE;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    `DCPF_ASSERT_IMP(a_frame_holds_beat, step_reg != STEP_IDLE, out_valid_reg, "frame in progress with empty output")
    `DCPF_ASSERT_IMP(a_eof_ends_frame, out_valid_reg && out_reg.kind == KIND_TX && out_reg.end_of_frame, step_reg == STEP_IDLE, "frame end while serializer busy")
    `DCPF_ASSERT_IMP(a_reply_outside_frame, out_valid_reg && out_reg.kind != KIND_TX, step_reg == STEP_IDLE, "reply beat inside a transmit frame")
    `DCPF_ASSERT_IMP(a_pop_only_valid, job_pop, job_valid, "pop from an empty queue")

endmodule

`default_nettype wire

@@ sv/daisy_chain_pec_framer_checker_top.sv @@
// ---------------------------------------------------------------------------
// daisy_chain_pec_framer_checker_top
// CRC-15 PEC command framer and per-device reply checker for a daisy chain.
// ---------------------------------------------------------------------------
// A command item produces a four-beat transmit frame (command high, command
// low, PEC high, PEC low; PEC is CRC-15 poly 0x4599 seed 16, sent shifted
// left by one). Each later reply byte is framed per device: six data bytes
// pass through as data beats, two PEC bytes yield one check beat carrying
// pec_ok and the running status, with end_of_frame on the last device. A
// link fault gives one abort beat. The front end accepts one item every
// cycle while the four-entry job queue has room; reply bytes and faults
// sustain one item per cycle while result_stall is low. A command holds
// the back-end serializer for its four beats; it takes no job meanwhile.
// Results pass the job queue and output register. cfg_* is always ready;
// the user must write the chain_length register only while idle (unchecked).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module daisy_chain_pec_framer_checker_top #(
    parameter int unsigned QUEUE_DEPTH = dcpf_pkg::JOB_QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // input items
    input  wire logic                item_valid,
    output logic                     item_stall,
    input  wire dcpf_pkg::in_item_t  item,
    // result beats
    output logic                     result_valid,
    input  wire logic                result_stall,
    output dcpf_pkg::out_item_t      result,
    // chain length register
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [5:0]          cfg_data
);
    import dcpf_pkg::*;

    logic job_push;
    job_t job_in;
    logic queue_full;
    logic queue_empty;
    logic job_pop;
    job_t job_head;

    // classify items and keep the reply framing state
    dcpf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .job_push   (job_push),
        .job        (job_in),
        .queue_full (queue_full)
    );

    // hold jobs so a stalled output does not block accepting items
    dcpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (job_in),
        .full  (queue_full),
        .pop   (job_pop),
        .dout  (job_head),
        .empty (queue_empty)
    );

    // expand jobs into beats; the output register parts the two sides
    dcpf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (!queue_empty),
        .job          (job_head),
        .job_pop      (job_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
